FILE: rtl/wsd_pkg.sv
package wsd_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_RESERVED = 2'd1;
   localparam logic [1:0] ERR_FRAGMENT = 2'd2;
   localparam logic [1:0] ERR_PROTOCOL = 2'd3;

   // opcodes
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam int LEN_W = 63;

   // one result beat
   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       opcode;
      logic             masked;
      logic [LEN_W-1:0] length;
      logic [3:0]       hdr_size;
      logic [7:0]       pbyte;
      logic             eof;
      logic [1:0]       err;
   } result_type;

endpackage

FILE: rtl/wsd_parser.sv
module wsd_parser
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_in,
   output logic       emit,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_FIRST, PH_SECOND, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_DEAD
   } phase_type;

   localparam logic [3:0] HCNT_EXT2_DONE = 4'd4;
   localparam logic [3:0] HCNT_EXT8_DONE = 4'd10;
   localparam logic [3:0] HCNT_KEY_SHORT = 4'd6;
   localparam logic [3:0] HCNT_KEY_EXT2  = 4'd8;
   localparam logic [3:0] HCNT_KEY_EXT8  = 4'd14;
   localparam logic [63:0] CTRL_MAX_LEN  = 64'd125;

   phase_type        phase_ff, phase_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             mask_ff, mask_in;
   logic [63:0]      len_ff, len_in;
   logic [3:0]       hcnt_ff, hcnt_in;
   logic [31:0]      key_ff, key_in;
   logic [1:0]       idx_ff, idx_in;
   logic             ext_ff, ext_in;
   logic             ext8_ff, ext8_in;
   logic [LEN_W-1:0] rem_ff, rem_in;

   logic [1:0] fail_code;
   logic       len_done, hdr_done, known_op, pay_eof;
   logic [7:0] key_byte;
   logic [3:0] len_stop, key_stop;

   // opcode check on the first header byte
   always_comb begin
      known_op = (byte_in[3:0] == OP_TEXT) || (byte_in[3:0] == OP_BINARY) ||
                 (byte_in[3:0] == OP_CLOSE) || (byte_in[3:0] == OP_PING) ||
                 (byte_in[3:0] == OP_PONG);
   end

   // current mask key byte, first key byte in the top lane
   always_comb begin
      unique case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // header byte counts that close the length and the key
   assign len_stop = ext8_ff ? HCNT_EXT8_DONE : HCNT_EXT2_DONE;
   assign key_stop = !ext_ff ? HCNT_KEY_SHORT :
                     (ext8_ff ? HCNT_KEY_EXT8 : HCNT_KEY_EXT2);

   // next state and result
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      hcnt_in   = hcnt_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      ext_in    = ext_ff;
      ext8_in   = ext8_ff;
      rem_in    = rem_ff;
      fail_code = ERR_NONE;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      pay_eof   = (rem_ff == {{(LEN_W-1){1'b0}}, 1'b1});
      emit      = 1'b0;
      res       = '0;

      unique case (phase_ff)
         PH_FIRST: begin
            if ((byte_in & 8'h70) != 8'h00) begin
               fail_code = ERR_RESERVED;
            end else if (!byte_in[7]) begin
               fail_code = ERR_FRAGMENT;
            end else if (!known_op) begin
               fail_code = ERR_PROTOCOL;
            end else begin
               opcode_in = byte_in[3:0];
               hcnt_in   = 4'd1;
               phase_in  = PH_SECOND;
            end
         end
         PH_SECOND: begin
            mask_in = byte_in[7];
            key_in  = '0;
            hcnt_in = 4'd2;
            if (byte_in[6:0] < 7'd126) begin
               ext_in   = 1'b0;
               len_in   = {57'd0, byte_in[6:0]};
               len_done = 1'b1;
            end else begin
               ext_in   = 1'b1;
               ext8_in  = (byte_in[6:0] == 7'd127);
               len_in   = '0;
               phase_in = PH_EXTLEN;
            end
         end
         PH_EXTLEN: begin
            len_in  = {len_ff[55:0], byte_in};
            hcnt_in = hcnt_ff + 4'd1;
            if (hcnt_in == len_stop) begin
               len_done = 1'b1;
            end
         end
         PH_KEY: begin
            key_in  = {key_ff[23:0], byte_in};
            hcnt_in = hcnt_ff + 4'd1;
            if (hcnt_ff == key_stop - 4'd1) begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            idx_in       = idx_ff + 2'd1;
            rem_in       = rem_ff - {{(LEN_W-1){1'b0}}, 1'b1};
            emit         = 1'b1;
            res.kind     = KIND_PAYLOAD;
            res.opcode   = opcode_ff;
            res.masked   = mask_ff;
            res.length   = len_ff[LEN_W-1:0];
            res.hdr_size = hcnt_ff;
            res.pbyte    = byte_in ^ key_byte;
            res.eof      = pay_eof;
            if (pay_eof) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
         end
      endcase

      // length checks once the length is complete
      if (len_done) begin
         if (len_in[63] || (opcode_in[3] && (len_in > CTRL_MAX_LEN))) begin
            fail_code = ERR_PROTOCOL;
         end else if (mask_in) begin
            phase_in = PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // header descriptor
      if (hdr_done) begin
         rem_in       = len_in[LEN_W-1:0];
         idx_in       = 2'd0;
         emit         = 1'b1;
         res.kind     = KIND_HEADER;
         res.opcode   = opcode_in;
         res.masked   = mask_in;
         res.length   = len_in[LEN_W-1:0];
         res.hdr_size = hcnt_in;
         res.eof      = (len_in == 64'd0);
         phase_in     = (len_in == 64'd0) ? PH_FIRST : PH_PAYLOAD;
      end

      // error report, sticky
      if (fail_code != ERR_NONE) begin
         emit     = 1'b1;
         res      = '0;
         res.kind = KIND_ERROR;
         res.err  = fail_code;
         phase_in = PH_DEAD;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         len_ff    <= '0;
         hcnt_ff   <= '0;
         key_ff    <= '0;
         idx_ff    <= '0;
         ext_ff    <= 1'b0;
         ext8_ff   <= 1'b0;
         rem_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         hcnt_ff   <= hcnt_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         ext_ff    <= ext_in;
         ext8_ff   <= ext8_in;
         rem_ff    <= rem_in;
      end
   end

endmodule

FILE: rtl/wsd_rsp_reg.sv
module wsd_rsp_reg
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res_in,
   input  logic       rsp_stall,
   output logic       room,
   output logic       rsp_valid,
   output result_type rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   // register can take a beat when empty or being drained
   assign room     = !valid_ff || !rsp_stall;
   assign valid_in = room ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (room && load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

FILE: rtl/websocket_frame_deframer_unit.sv
// An accepted stream byte is registered in the input register and its result beat in the result register.
// Throughput: one byte per cycle; the input register and the result
// register pass a beat each cycle unless the result side stalls.
// Header bytes give no result until the header is complete, unless one is in error.
// Reset (synchronous, active high) returns to expect the first header byte.
module websocket_frame_deframer_unit
   import wsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_stream_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_is_masked,
   output logic [LEN_W-1:0] rsp_frame_length,
   output logic [3:0]       rsp_header_size,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_end_of_frame,
   output logic [1:0]       rsp_error_code
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       room, step, emit;
   result_type res, rsp_res;

   // input register advances whenever the result register has room
   assign step        = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_byte_ff),
      .emit    (emit),
      .res     (res)
   );

   wsd_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (step && emit),
      .res_in    (res),
      .rsp_stall (rsp_stall),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   assign rsp_result_kind  = rsp_res.kind;
   assign rsp_frame_opcode = rsp_res.opcode;
   assign rsp_is_masked    = rsp_res.masked;
   assign rsp_frame_length = rsp_res.length;
   assign rsp_header_size  = rsp_res.hdr_size;
   assign rsp_payload_byte = rsp_res.pbyte;
   assign rsp_end_of_frame = rsp_res.eof;
   assign rsp_error_code   = rsp_res.err;

endmodule
